### hw/rtl/lkv_pkg.sv
// ============================================================================
// lkv_pkg
// Shared constants, payload structs and control types of the LRU key-value
// cache.
// ============================================================================
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int CAP_RESET  = 16;

    localparam int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
    localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
    } resp_t;

    typedef enum logic [1:0] {
        RCY_IDLE,
        RCY_TOUCH,
        RCY_INSERT
    } rcy_op_t;

    typedef struct packed {
        rcy_op_t              op;
        logic [SLOT_BITS-1:0] slot;
    } rcy_cmd_t;

    typedef struct packed {
        logic [ENTRIES-1:0]   valid;
        logic [SLOT_BITS-1:0] ins_slot;
        logic                 ins_ok;
    } rcy_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/lru_key_value_cache.sv
// ============================================================================
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
//
//   channel   | ports                    | direction | payload
//   ----------+--------------------------+-----------+------------------------
//   request   | s_valid s_ready s_req    | in        | kind, key, value
//   response  | m_valid m_ready m_resp   | out       | found, read_value
//   config    | cfg_we cfg_wdata         | in        | capacity
//
// One transaction scans every slot: the key scan
// reads the entry RAM through its single read port, one slot per cycle.
// Valid bits and count reset at once; ranks and the entry RAM are never cleared.
// A new request is taken while a finished response waits on m_ready; a
// stalled response holds the block in its final state until it is taken.
// ============================================================================
module lru_key_value_cache (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lkv_pkg::req_t                s_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lkv_pkg::resp_t               m_resp,
    input  logic                         cfg_we,
    input  logic [lkv_pkg::CAP_BITS-1:0] cfg_wdata
);

    lkv_pkg::state_t                state_reg, state_next;
    lkv_pkg::req_t                  req_reg;
    logic [lkv_pkg::COUNT_BITS-1:0] scan_addr_reg;
    logic                           rd_pend_reg;
    logic [lkv_pkg::SLOT_BITS-1:0]  rd_slot_reg;
    logic                           hit_reg;
    logic [lkv_pkg::SLOT_BITS-1:0]  hit_slot_reg;
    logic [lkv_pkg::VALUE_BITS-1:0] hit_value_reg;
    logic                           m_valid_reg;
    lkv_pkg::resp_t                 m_resp_reg;
    logic [lkv_pkg::CAP_BITS-1:0]   cap_reg;

    logic                           accept;
    logic                           out_load;
    logic                           ram_re, ram_we;
    logic [lkv_pkg::SLOT_BITS-1:0]  ram_raddr, ram_waddr;
    logic [lkv_pkg::ENTRY_BITS-1:0] ram_wdata, ram_rdata;
    logic [lkv_pkg::KEY_BITS-1:0]   rd_key;
    logic [lkv_pkg::VALUE_BITS-1:0] rd_value;
    lkv_pkg::rcy_cmd_t              rcy_cmd;
    lkv_pkg::rcy_stat_t             rcy_stat;

    lkv_ram #(
        .WIDTH (lkv_pkg::ENTRY_BITS),
        .DEPTH (lkv_pkg::ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lkv_recency u_recency (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (rcy_cmd),
        .capacity (cap_reg),
        .stat     (rcy_stat)
    );

    assign s_ready   = (state_reg == lkv_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_resp    = m_resp_reg;
    assign ram_raddr = scan_addr_reg[lkv_pkg::SLOT_BITS-1:0];
    assign rd_key    = ram_rdata[lkv_pkg::ENTRY_BITS-1 -: lkv_pkg::KEY_BITS];
    assign rd_value  = ram_rdata[lkv_pkg::VALUE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lkv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = hit_slot_reg;
        ram_wdata   = {req_reg.key, req_reg.value};
        rcy_cmd.op  = lkv_pkg::RCY_IDLE;
        rcy_cmd.slot = hit_slot_reg;
        out_load    = 1'b0;
        case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                ram_re = (scan_addr_reg != lkv_pkg::COUNT_BITS'(lkv_pkg::ENTRIES));
                if (!ram_re && rd_pend_reg) begin
                    state_next = lkv_pkg::ST_UPDATE;
                end
            end
            lkv_pkg::ST_UPDATE: begin
                if (hit_reg) begin
                    rcy_cmd.op = lkv_pkg::RCY_TOUCH;
                    ram_we     = (req_reg.kind == lkv_pkg::KIND_PUT);
                end else if (req_reg.kind == lkv_pkg::KIND_PUT) begin
                    rcy_cmd.op = lkv_pkg::RCY_INSERT;
                    ram_waddr  = rcy_stat.ins_slot;
                    ram_we     = rcy_stat.ins_ok;
                end
                state_next = lkv_pkg::ST_DONE;
            end
            lkv_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            cap_reg     <= lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (accept) begin
                rd_pend_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end else if (state_reg == lkv_pkg::ST_SCAN) begin
                rd_pend_reg <= ram_re;
                if (rd_pend_reg && !hit_reg && rcy_stat.valid[rd_slot_reg] &&
                    rd_key == req_reg.key) begin
                    hit_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg       <= s_req;
            scan_addr_reg <= '0;
        end else if (ram_re) begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        if (ram_re) begin
            rd_slot_reg <= ram_raddr;
        end
        if (state_reg == lkv_pkg::ST_SCAN && rd_pend_reg && !hit_reg &&
            rcy_stat.valid[rd_slot_reg] && rd_key == req_reg.key) begin
            hit_slot_reg  <= rd_slot_reg;
            hit_value_reg <= rd_value;
        end
        if (out_load) begin
            m_resp_reg.found      <= hit_reg;
            m_resp_reg.read_value <= (hit_reg && req_reg.kind == lkv_pkg::KIND_GET) ?
                                     hit_value_reg : '0;
        end
    end

`ifndef SYNTHESIS
    a_resp_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == lkv_pkg::ST_DONE))
        else $error("response raised outside the final state");

    a_hit_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lkv_pkg::ST_UPDATE && hit_reg) |-> rcy_stat.valid[hit_slot_reg])
        else $error("hit recorded on an invalid slot");

    a_insert_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lkv_pkg::ST_UPDATE && !hit_reg &&
         req_reg.kind == lkv_pkg::KIND_PUT) |-> rcy_stat.ins_ok)
        else $error("no free slot for a new key");

    a_scan_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lkv_pkg::ST_UPDATE) |-> $past(rd_pend_reg && !ram_re))
        else $error("update entered before the last slot was compared");
`endif

endmodule

### hw/rtl/lkv_ram.sv
// ============================================================================
// lkv_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/lkv_recency.sv
// ============================================================================
// lkv_recency
// Per-slot valid bits, recency ranks and entry count. Applies a touch or an
// insert (with eviction against capacity) across all slots in one registered update.
// ============================================================================
module lkv_recency (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lkv_pkg::rcy_cmd_t             cmd,
    input  logic [lkv_pkg::CAP_BITS-1:0]  capacity,
    output lkv_pkg::rcy_stat_t            stat
);

    logic [lkv_pkg::ENTRIES-1:0]    valid_reg, valid_next;
    logic [lkv_pkg::SLOT_BITS-1:0]  rank_reg  [lkv_pkg::ENTRIES];
    logic [lkv_pkg::SLOT_BITS-1:0]  rank_next [lkv_pkg::ENTRIES];
    logic [lkv_pkg::COUNT_BITS-1:0] count_reg, count_next;

    logic [lkv_pkg::SLOT_BITS-1:0]  hit_rank;
    logic [lkv_pkg::ENTRIES-1:0]    valid_a, valid_b;
    logic [lkv_pkg::SLOT_BITS-1:0]  rank_b [lkv_pkg::ENTRIES];
    logic [lkv_pkg::COUNT_BITS-1:0] cnt_a, cnt_b, cnt_c;
    logic                           pre_drop, post_drop;
    logic                           ins_ok;
    logic [lkv_pkg::SLOT_BITS-1:0]  ins_slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            rank_reg[i] <= rank_next[i];
        end
    end

    always_comb begin
        hit_rank = rank_reg[cmd.slot];

        // evict least recent first when the store is full
        valid_a  = valid_reg;
        cnt_a    = count_reg;
        pre_drop = 1'b0;
        if (count_reg >= lkv_pkg::COUNT_BITS'(lkv_pkg::ENTRIES)) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                if (!pre_drop && valid_reg[i] &&
                    rank_reg[i] == lkv_pkg::SLOT_BITS'(count_reg - 1'b1)) begin
                    valid_a[i] = 1'b0;
                    pre_drop   = 1'b1;
                end
            end
            if (pre_drop) begin
                cnt_a = count_reg - 1'b1;
            end
        end

        ins_ok   = 1'b0;
        ins_slot = '0;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (!ins_ok && !valid_a[i]) begin
                ins_ok   = 1'b1;
                ins_slot = lkv_pkg::SLOT_BITS'(i);
            end
        end

        valid_b = valid_a;
        cnt_b   = cnt_a + 1'b1;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            rank_b[i] = valid_a[i] ? rank_reg[i] + 1'b1 : rank_reg[i];
            if (lkv_pkg::SLOT_BITS'(i) == ins_slot) begin
                rank_b[i]  = '0;
                valid_b[i] = 1'b1;
            end
        end

        // over capacity after insert: drop the tail
        cnt_c     = cnt_b;
        post_drop = 1'b0;
        if (lkv_pkg::CMP_BITS'(cnt_b) > lkv_pkg::CMP_BITS'(capacity)) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                if (!post_drop && valid_b[i] &&
                    rank_b[i] == lkv_pkg::SLOT_BITS'(cnt_b - 1'b1)) begin
                    valid_b[i] = 1'b0;
                    post_drop  = 1'b1;
                end
            end
            if (post_drop) begin
                cnt_c = cnt_b - 1'b1;
            end
        end

        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end

        case (cmd.op)
            lkv_pkg::RCY_TOUCH: begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (lkv_pkg::SLOT_BITS'(i) == cmd.slot) begin
                        rank_next[i] = '0;
                    end else if (valid_reg[i] && rank_reg[i] < hit_rank) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
            end
            lkv_pkg::RCY_INSERT: begin
                if (ins_ok) begin
                    valid_next = valid_b;
                    count_next = cnt_c;
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                        rank_next[i] = rank_b[i];
                    end
                end else begin
                    valid_next = valid_a;
                    count_next = cnt_a;
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.valid    = valid_reg;
    assign stat.ins_slot = ins_slot;
    assign stat.ins_ok   = ins_ok;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count disagrees with valid bits");
`endif

endmodule
